/* rtl/ssd_pkg.sv */
package ssd_pkg;

    // command codes carried in the slave-side tuser
    typedef enum logic [2:0] {
        OP_WRITE_CHAR = 3'd0,
        OP_SET_ICON   = 3'd1,
        OP_CLEAR_ICON = 3'd2,
        OP_FLASH_ICON = 3'd3,
        OP_FLASH_POS  = 3'd4,
        OP_CLEAR      = 3'd5,
        OP_SCAN_TICK  = 3'd6
    } t_opcode;

    // configuration register indexes
    localparam logic CFG_COLON_MASK   = 1'b0;
    localparam logic CFG_BLINK_PERIOD = 1'b1;

    localparam logic [7:0] BLINK_PERIOD_RESET = 8'd250;
    localparam logic [7:0] GLYPH_MINUS        = 8'h40;
    localparam logic [7:0] ALL_ICONS          = 8'hff;

    typedef enum logic [0:0] {
        OS_EMPTY,
        OS_FULL
    } t_out_state;

    // one-hot commands from controller to datapath
    typedef struct packed {
        logic write_char;
        logic set_icon;
        logic clear_icon;
        logic flash_icon;
        logic flash_pos;
        logic clear_all;
        logic scan_tick;
    } t_dp_cmd;

    typedef enum logic [1:0] {
        CH_NONE,
        CH_GLYPH,
        CH_COLON
    } t_char_class;

    typedef struct packed {
        t_char_class cls;
        logic [7:0]  glyph;
    } t_glyph;

    localparam logic [7:0] DIGIT_GLYPH [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    localparam logic [7:0] UPPER_GLYPH [26] = '{
        8'h77, 8'h40, 8'h39, 8'h3f, 8'h79, 8'h71, 8'h40, 8'h76, 8'h06, 8'h1e,
        8'h40, 8'h38, 8'h40, 8'h37, 8'h3f, 8'h73, 8'h40, 8'h50, 8'h6d, 8'h40,
        8'h3e, 8'h3e, 8'h40, 8'h76, 8'h40, 8'h5b
    };

    localparam logic [7:0] LOWER_GLYPH [26] = '{
        8'h77, 8'h7c, 8'h58, 8'h5e, 8'h79, 8'h71, 8'h40, 8'h40, 8'h40, 8'h40,
        8'h40, 8'h38, 8'h40, 8'h54, 8'h5c, 8'h73, 8'h67, 8'h50, 8'h40, 8'h40,
        8'h3e, 8'h3e, 8'h40, 8'h40, 8'h40, 8'h40
    };

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_COLON   = 8'h3a;
    localparam logic [7:0] CHAR_MINUS   = 8'h2d;

    // ascii to glyph; the colon is class colon, anything else without a glyph is class none
    function automatic t_glyph ssd_decode_char(input logic [7:0] c);
        t_glyph     res;
        logic [7:0] idx;
        res.cls   = CH_NONE;
        res.glyph = 8'h00;
        idx       = 8'h00;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            idx       = c - CHAR_ZERO;
            res.cls   = CH_GLYPH;
            res.glyph = DIGIT_GLYPH[idx[3:0]];
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            idx       = c - CHAR_LOWER_A;
            res.cls   = CH_GLYPH;
            res.glyph = LOWER_GLYPH[idx[4:0]];
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            idx       = c - CHAR_UPPER_A;
            res.cls   = CH_GLYPH;
            res.glyph = UPPER_GLYPH[idx[4:0]];
        end else if (c == CHAR_COLON) begin
            res.cls   = CH_COLON;
        end else if (c == CHAR_MINUS) begin
            res.cls   = CH_GLYPH;
            res.glyph = GLYPH_MINUS;
        end
        return res;
    endfunction

endpackage

/* rtl/ssd_ctrl.sv */
module ssd_ctrl
    import ssd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_opcode,
    input  logic       i_out_ready,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    t_out_state r_state;
    t_out_state n_state;
    logic       accept;
    logic       is_tick;

    assign is_tick = (i_opcode == OP_SCAN_TICK);
    assign accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= OS_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    // result register occupancy
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            OS_EMPTY: begin
                if (accept && is_tick) n_state = OS_FULL;
            end
            OS_FULL: begin
                if (i_out_ready && !(accept && is_tick)) n_state = OS_EMPTY;
            end
            default: n_state = OS_EMPTY;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == OS_EMPTY) || i_out_ready;
        o_out_valid = (r_state == OS_FULL);
        o_cmd       = '0;
        if (accept) begin
            unique case (t_opcode'(i_opcode))
                OP_WRITE_CHAR: o_cmd.write_char = 1'b1;
                OP_SET_ICON:   o_cmd.set_icon   = 1'b1;
                OP_CLEAR_ICON: o_cmd.clear_icon = 1'b1;
                OP_FLASH_ICON: o_cmd.flash_icon = 1'b1;
                OP_FLASH_POS:  o_cmd.flash_pos  = 1'b1;
                OP_CLEAR:      o_cmd.clear_all  = 1'b1;
                OP_SCAN_TICK:  o_cmd.scan_tick  = 1'b1;
                default:       o_cmd            = '0;
            endcase
        end
    end

endmodule

/* rtl/ssd_datapath.sv */
module ssd_datapath
    import ssd_pkg::*;
#(
    parameter int NUM_POSITIONS = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [7:0] i_char_code,
    input  logic [2:0] i_position,
    input  logic [7:0] i_icon_mask,
    input  logic       i_cfg_we,
    input  logic       i_cfg_addr,
    input  logic [7:0] i_cfg_data,
    output logic [4:0] o_digit_enable,
    output logic [6:0] o_segment_drive
);

    localparam int PW = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(NUM_POSITIONS - 1);

    logic [7:0]    r_store [NUM_POSITIONS];
    logic [7:0]    n_store [NUM_POSITIONS];
    logic [7:0]    r_blink_mask, n_blink_mask;
    logic [7:0]    r_blink_count, n_blink_count;
    logic          r_blink_phase, n_blink_phase;
    logic [PW-1:0] r_scan_pos, n_scan_pos;
    logic [7:0]    r_colon_mask;
    logic [7:0]    r_blink_period;
    logic [4:0]    r_out_enable, n_out_enable;
    logic [6:0]    r_out_seg, n_out_seg;

    t_glyph        glyph;
    logic          pos_ok;
    logic [PW-1:0] pos_idx;
    logic [7:0]    count_inc;
    logic [7:0]    seg;
    logic [7:0]    sel_onehot;

    assign glyph   = ssd_decode_char(i_char_code);
    assign pos_ok  = {1'b0, i_position} < 4'(NUM_POSITIONS);
    assign pos_idx = i_position[PW-1:0];

    always_comb begin
        n_store       = r_store;
        n_blink_mask  = r_blink_mask;
        n_blink_count = r_blink_count;
        n_blink_phase = r_blink_phase;
        n_scan_pos    = r_scan_pos;
        n_out_enable  = r_out_enable;
        n_out_seg     = r_out_seg;
        count_inc     = r_blink_count + 8'd1;
        seg           = 8'h00;
        sel_onehot    = 8'h00;

        if (i_cmd.write_char) begin
            if (glyph.cls == CH_GLYPH && pos_ok) begin
                n_store[pos_idx] = glyph.glyph;
            end else if (glyph.cls == CH_COLON) begin
                n_store[LAST_POS] = r_store[LAST_POS] | r_colon_mask;
            end
        end
        if (i_cmd.set_icon) n_store[LAST_POS] = r_store[LAST_POS] | i_icon_mask;
        if (i_cmd.clear_icon) n_store[LAST_POS] = r_store[LAST_POS] & ~i_icon_mask;
        if (i_cmd.flash_icon) n_blink_mask = r_blink_mask | i_icon_mask;
        if (i_cmd.flash_pos && i_position == 3'(NUM_POSITIONS - 1)) begin
            n_blink_mask = ALL_ICONS;
        end
        if (i_cmd.clear_all) begin
            for (int i = 0; i < NUM_POSITIONS; i++) n_store[i] = 8'h00;
            n_blink_mask = 8'h00;
        end
        if (i_cmd.scan_tick) begin
            // period of zero only matches after the wrap, i.e. 256 ticks
            if (count_inc == r_blink_period) begin
                n_blink_count = 8'd0;
                n_blink_phase = ~r_blink_phase;
            end else begin
                n_blink_count = count_inc;
            end
            seg = r_store[r_scan_pos];
            if (r_scan_pos == LAST_POS && n_blink_phase) seg = seg ^ r_blink_mask;
            sel_onehot   = 8'd1 << r_scan_pos;
            n_out_enable = sel_onehot[4:0];
            n_out_seg    = ~seg[6:0];
            n_scan_pos   = (r_scan_pos == LAST_POS) ? '0 : r_scan_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_POSITIONS; i++) r_store[i] <= 8'h00;
            r_blink_mask   <= 8'h00;
            r_blink_count  <= 8'd0;
            r_blink_phase  <= 1'b0;
            r_scan_pos     <= '0;
            r_colon_mask   <= 8'h00;
            r_blink_period <= BLINK_PERIOD_RESET;
        end else begin
            r_store       <= n_store;
            r_blink_mask  <= n_blink_mask;
            r_blink_count <= n_blink_count;
            r_blink_phase <= n_blink_phase;
            r_scan_pos    <= n_scan_pos;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_COLON_MASK:   r_colon_mask   <= i_cfg_data;
                    CFG_BLINK_PERIOD: r_blink_period <= i_cfg_data;
                    default:          r_colon_mask   <= r_colon_mask;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_enable <= n_out_enable;
        r_out_seg    <= n_out_seg;
    end

    assign o_digit_enable  = r_out_enable;
    assign o_segment_drive = r_out_seg;

endmodule

/* rtl/seven_segment_scan_display.sv */
// multiplexed seven-segment display driver: NUM_POSITIONS positions, the last
// being the status/icon position and the others character digits. every
// slave-side transaction is a command (opcode in tuser); only a scan tick
// produces a master-side transaction, carrying the one-hot enable of the
// scanned position and its active-low segments a..g. one command is taken per clock
// unless stalled; each is a single register update in the datapath. a scan tick's
// result is offered from the cycle after its transaction. any command, not only a
// scan tick, waits while the result register still holds an untaken result and the
// master side is not ready in that cycle. colon_mask (index 0) and blink_period
// (index 1) are written through the cfg port; the user must write them only while
// idle, which the block does not enforce. blink_period 0 behaves as 256 ticks.
module seven_segment_scan_display
    import ssd_pkg::*;
#(
    parameter int NUM_POSITIONS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // char_code[7:0], position[10:8], icon_mask[18:11]
    input  logic [2:0]  s_axis_tuser,  // opcode[2:0]
    // scan result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // digit_enable[4:0], segment_drive[11:5]
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_data
);

    t_dp_cmd    cmd;
    logic [4:0] digit_enable;
    logic [6:0] segment_drive;

    // controller owns both handshakes and decodes the opcode
    ssd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_opcode    (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    // display store, blink timer, scan counter and result register
    ssd_datapath #(
        .NUM_POSITIONS (NUM_POSITIONS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_char_code     (s_axis_tdata[7:0]),
        .i_position      (s_axis_tdata[10:8]),
        .i_icon_mask     (s_axis_tdata[18:11]),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .o_digit_enable  (digit_enable),
        .o_segment_drive (segment_drive)
    );

    // pad to whole bytes
    assign m_axis_tdata = {4'b0000, segment_drive, digit_enable};

endmodule

/* rtl/ssd_checker.sv */
module ssd_checker
    import ssd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    logic in_xact;
    logic tick_xact;
    logic out_free;

    assign in_xact   = s_axis_tvalid && s_axis_tready;
    assign tick_xact = in_xact && (s_axis_tuser == OP_SCAN_TICK);
    assign out_free  = !m_axis_tvalid || m_axis_tready;

    // a pending result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped before transaction");

    // every accepted scan tick yields a result next cycle
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_xact |=> m_axis_tvalid)
        else $error("scan tick without result");

    // other commands never invent a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_free && !tick_xact) |=> !m_axis_tvalid)
        else $error("result without scan tick");

    // at most one position lit, padding clear
    a_enable_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($onehot0(m_axis_tdata[4:0]) && m_axis_tdata[15:12] == 4'd0))
        else $error("bad enable or padding");

endmodule

bind seven_segment_scan_display ssd_checker u_ssd_checker (.*);

/* dv/scan_display_checker.sv */
module scan_display_checker
    import ssd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_cmd_tvalid,
    input  logic        i_cmd_tready,
    input  logic [23:0] i_cmd_tdata,   // char_code[7:0], position[10:8], icon_mask[18:11]
    input  logic [2:0]  i_cmd_tuser,   // opcode[2:0]
    // scan result channel
    input  logic        i_scan_tvalid,
    input  logic        i_scan_tready,
    input  logic [15:0] i_scan_tdata,  // digit_enable[4:0], segment_drive[11:5]
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    output int          o_pending,
    output int          o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_POS    = 5;
    localparam int STATUS_POS = NUM_POS - 1;

    typedef struct packed {
        logic [4:0] enable;
        logic [6:0] segments;
    } t_scan_frame;

    logic [7:0]  colon_mask;
    logic [7:0]  blink_period;
    logic [7:0]  seg_store [NUM_POS];
    logic [7:0]  status_blink;
    logic [7:0]  blink_count;
    logic        blink_on;
    logic [2:0]  scan_pos;
    t_scan_frame scan_frames_due [$];
    int          error_count = 0;

    task automatic put_glyph(input logic [2:0] pos, input logic [7:0] glyph);
        if (pos < NUM_POS) begin
            seg_store[pos] = glyph;
        end
    endtask

    // display model: updates the stored state and queues the frame a tick drives
    task automatic advance_display(input logic [2:0] op, input logic [7:0] ch,
                                   input logic [2:0] pos, input logic [7:0] icons);
        logic [2:0]  p;
        logic [7:0]  seg;
        t_scan_frame frame;
        case (op)
            OP_WRITE_CHAR: begin
                if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                    put_glyph(pos, DIGIT_GLYPH[4'(ch - CHAR_ZERO)]);
                end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
                    put_glyph(pos, LOWER_GLYPH[5'(ch - CHAR_LOWER_A)]);
                end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
                    put_glyph(pos, UPPER_GLYPH[5'(ch - CHAR_UPPER_A)]);
                end else if (ch == CHAR_COLON) begin
                    seg_store[STATUS_POS] |= colon_mask;
                end else if (ch == CHAR_MINUS) begin
                    put_glyph(pos, GLYPH_MINUS);
                end
            end
            OP_SET_ICON:   seg_store[STATUS_POS] |= icons;
            OP_CLEAR_ICON: seg_store[STATUS_POS] &= ~icons;
            OP_FLASH_ICON: status_blink |= icons;
            OP_FLASH_POS: begin
                if (pos == STATUS_POS) begin
                    status_blink = ALL_ICONS;
                end
            end
            OP_CLEAR: begin
                foreach (seg_store[i]) begin
                    seg_store[i] = 8'h00;
                end
                status_blink = 8'h00;
            end
            OP_SCAN_TICK: begin
                // 8-bit counter, so period 0 toggles after 256 ticks
                blink_count = blink_count + 8'd1;
                if (blink_count == blink_period) begin
                    blink_count = 8'd0;
                    blink_on    = ~blink_on;
                end
                p = (scan_pos >= NUM_POS) ? 3'd0 : scan_pos;
                seg = seg_store[p];
                if (p == STATUS_POS && blink_on) begin
                    seg ^= status_blink;
                end
                frame.enable   = 5'b00001 << p;
                frame.segments = ~seg[6:0];
                scan_frames_due.push_back(frame);
                scan_pos = (p >= STATUS_POS) ? 3'd0 : p + 3'd1;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_scan_frame want;
        if (!i_rst_n) begin
            colon_mask   = 8'h00;
            blink_period = BLINK_PERIOD_RESET;
            foreach (seg_store[i]) begin
                seg_store[i] = 8'h00;
            end
            status_blink = 8'h00;
            blink_count  = 8'h00;
            blink_on     = 1'b0;
            scan_pos     = 3'd0;
            scan_frames_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_COLON_MASK:   colon_mask   = i_cfg_data;
                    CFG_BLINK_PERIOD: blink_period = i_cfg_data;
                    default: ;
                endcase
            end
            // results come from earlier ticks, so compare before queueing new ones
            if (i_scan_tvalid && i_scan_tready) begin
                if (scan_frames_due.size() == 0) begin
                    $error("scan result %0h with no expectation waiting", i_scan_tdata);
                    error_count++;
                end else begin
                    want = scan_frames_due.pop_front();
                    if (i_scan_tdata[4:0] !== want.enable) begin
                        $error("digit_enable mismatch: expected %0h, actual %0h",
                               want.enable, i_scan_tdata[4:0]);
                        error_count++;
                    end
                    if (i_scan_tdata[11:5] !== want.segments) begin
                        $error("segment_drive mismatch: expected %0h, actual %0h",
                               want.segments, i_scan_tdata[11:5]);
                        error_count++;
                    end
                end
            end
            if (i_cmd_tvalid && i_cmd_tready) begin
                advance_display(i_cmd_tuser, i_cmd_tdata[7:0], i_cmd_tdata[10:8],
                                i_cmd_tdata[18:11]);
            end
        end
        o_pending <= scan_frames_due.size();
        o_errors  <= error_count;
    end

endmodule

/* dv/tb.sv */
module tb;
    import ssd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 4;     // result register plus margin
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 225;

    // opcode the block does not define: must change nothing
    localparam logic [2:0] OP_UNUSED = 3'd7;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // char_code[7:0], position[10:8], icon_mask[18:11]
    logic [2:0]  s_axis_tuser  = '0;   // opcode[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // digit_enable[4:0], segment_drive[11:5]
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_addr    = 1'b0;
    logic [7:0]  i_cfg_data    = '0;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int frames_pending;
    int fail_count;
    int quiet_cycles = 0;

    seven_segment_scan_display #(
        .NUM_POSITIONS(5)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data)
    );

    // prediction and comparison live beside the block
    scan_display_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_tvalid (s_axis_tvalid),
        .i_cmd_tready (s_axis_tready),
        .i_cmd_tdata  (s_axis_tdata),
        .i_cmd_tuser  (s_axis_tuser),
        .i_scan_tvalid(m_axis_tvalid),
        .i_scan_tready(m_axis_tready),
        .i_scan_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (frames_pending),
        .o_errors     (fail_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // receiver back-pressure, drawn afresh every cycle
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // watchdog: too long without a transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one command transaction; valid stays high afterwards unless a gap follows
    task automatic send_command(input logic [2:0] op, input logic [7:0] ch,
                                input logic [2:0] pos, input logic [7:0] icons);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, icons, pos, ch};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // hold off until every predicted frame has come, then let the block settle
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (frames_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [7:0] colon, input logic [7:0] period);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_COLON_MASK;
        i_cfg_data <= colon;
        @(posedge i_clk);
        i_cfg_addr <= CFG_BLINK_PERIOD;
        i_cfg_data <= period;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [2:0] op;
        logic [2:0] pos;
        logic [7:0] ch;
        logic [7:0] icons;
        logic [7:0] colon;
        logic [7:0] period;
        int         kind;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: short blink period so the phase flips within a few scans
        write_settings(8'h81, 8'd2);
        send_command(OP_WRITE_CHAR, CHAR_ZERO, 3'd0, 8'h00);
        send_command(OP_WRITE_CHAR, CHAR_UPPER_Z, 3'd1, 8'hff);
        send_command(OP_WRITE_CHAR, CHAR_LOWER_Z, 3'd2, 8'h00);
        send_command(OP_WRITE_CHAR, CHAR_MINUS, 3'd3, 8'h00);
        // a glyph on the status position replaces its bits
        send_command(OP_WRITE_CHAR, CHAR_UPPER_A, 3'd4, 8'h00);
        // colon lands on the status position whatever position is given
        send_command(OP_WRITE_CHAR, CHAR_COLON, 3'd7, 8'h00);
        // out-of-range position, non-printable and glyph-less characters
        send_command(OP_WRITE_CHAR, CHAR_NINE, 3'd7, 8'h00);
        send_command(OP_WRITE_CHAR, 8'h7f, 3'd0, 8'h00);
        send_command(OP_WRITE_CHAR, 8'h20, 3'd0, 8'h00);
        send_command(OP_WRITE_CHAR, 8'hff, 3'd0, 8'h00);
        send_command(OP_WRITE_CHAR, 8'h1f, 3'd0, 8'h00);
        // icon bits, including bit 7 which is never driven
        send_command(OP_SET_ICON, 8'h00, 3'd0, 8'hff);
        send_command(OP_CLEAR_ICON, 8'h00, 3'd0, 8'h0f);
        send_command(OP_FLASH_ICON, 8'h00, 3'd0, 8'h01);
        send_command(OP_FLASH_POS, 8'h00, 3'd3, 8'h00);
        send_command(OP_FLASH_POS, 8'h00, 3'd4, 8'h00);
        send_command(OP_UNUSED, 8'hff, 3'd7, 8'hff);
        repeat (5) send_command(OP_SCAN_TICK, 8'h00, 3'd0, 8'h00);
        // clear keeps counter, phase and scan position
        send_command(OP_CLEAR, 8'h00, 3'd0, 8'h00);
        repeat (2) send_command(OP_SCAN_TICK, 8'hff, 3'd7, 8'hff);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_for_results();
            case (phase % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 48; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 48; end
                default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
            endcase
            // extremes first, then a period of 0 (256 ticks) and short random periods
            case (phase)
                0:       begin colon = 8'h00;        period = 8'd1;   end
                1:       begin colon = 8'hff;        period = 8'd255; end
                2:       begin colon = 8'($urandom); period = 8'd3;   end
                3:       begin colon = 8'h80;        period = 8'd0;   end
                4:       begin colon = 8'h01;        period = 8'd2;   end
                5:       begin colon = 8'($urandom); period = 8'($urandom_range(8, 1)); end
                6:       begin colon = 8'($urandom); period = 8'd7;   end
                default: begin colon = 8'($urandom); period = 8'($urandom_range(4, 1)); end
            endcase
            write_settings(colon, period);

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // sender pause mid-phase until the result channel has drained
                if (k == PHASE_ITEMS / 2) begin
                    wait_for_results();
                end
                ch    = 8'($urandom);
                pos   = 3'($urandom_range(7));
                icons = 8'($urandom);
                kind  = int'($urandom_range(99));
                if (kind < 40) begin
                    op = OP_SCAN_TICK;
                end else if (kind < 65) begin
                    op = OP_WRITE_CHAR;
                    // mostly characters with a glyph on a real position
                    if ($urandom_range(4) != 0) begin
                        pos = 3'($urandom_range(4));
                    end
                    case ($urandom_range(7))
                        0:       ch = 8'(CHAR_ZERO + $urandom_range(9));
                        1:       ch = 8'(CHAR_UPPER_A + $urandom_range(25));
                        2:       ch = 8'(CHAR_LOWER_A + $urandom_range(25));
                        3:       ch = CHAR_MINUS;
                        4:       ch = CHAR_COLON;
                        5:       ch = 8'($urandom_range(8'h7e, 8'h20));
                        default: ;
                    endcase
                end else if (kind < 75) begin
                    op = OP_SET_ICON;
                end else if (kind < 82) begin
                    op = OP_CLEAR_ICON;
                end else if (kind < 87) begin
                    op = OP_FLASH_ICON;
                end else if (kind < 93) begin
                    op = OP_FLASH_POS;
                    if ($urandom_range(1) != 0) begin
                        pos = 3'd4;
                    end
                end else if (kind < 96) begin
                    op = OP_CLEAR;
                end else begin
                    op = OP_UNUSED;
                end
                send_command(op, ch, pos, icons);
            end
        end

        wait_for_results();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
